FILE: design/signed_int_to_decimal_ascii_macros.svh
// Assertion helpers for the RTL that checks itself.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_MACROS_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_MACROS_SVH

// same-cycle implication, held off during reset
`define SITDA_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sitda: same-cycle check failed");

// next-cycle implication, held off during reset
`define SITDA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sitda: next-cycle check failed");

`endif

FILE: design/sitda_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sitda_pkg;

    localparam logic [7:0] ASCII_ZERO  = 8'h30;
    localparam logic [7:0] ASCII_NINE  = 8'h39;
    localparam logic [7:0] ASCII_MINUS = 8'h2D;

    // sequencer states, one-hot
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_CONV = 5'b00010,
        S_SKIP = 5'b00100,
        S_SIGN = 5'b01000,
        S_EMIT = 5'b10000
    } t_state;

    // commands to the BCD register
    typedef struct packed {
        logic clear;  // zero all digits
        logic step;   // one shift-add-3 step, new bit in at the bottom
        logic shift;  // drop the top digit, zero in at the bottom
    } t_bcd_cmd;

endpackage

`default_nettype wire

FILE: design/sitda_dabble.sv
`timescale 1ns / 1ps
`default_nettype none

// One double-dabble step: add 3 to every digit of 5 or more, then shift the
// whole BCD word left by one with the new binary bit entering at the bottom.
module sitda_dabble #(
    parameter int NDIG = 10
) (
    input  wire logic [NDIG*4-1:0] i_bcd,
    input  wire logic              i_bit,
    output logic      [NDIG*4-1:0] o_bcd
);

    logic [NDIG*4-1:0] adj;

    always_comb begin
        for (int i = 0; i < NDIG; i++) begin
            if (i_bcd[i*4 +: 4] >= 4'd5) begin
                adj[i*4 +: 4] = i_bcd[i*4 +: 4] + 4'd3;
            end else begin
                adj[i*4 +: 4] = i_bcd[i*4 +: 4];
            end
        end
    end

    assign o_bcd = {adj[NDIG*4-2:0], i_bit};

endmodule

`default_nettype wire

FILE: design/sitda_bcd_reg.sv
`timescale 1ns / 1ps
`default_nettype none

// BCD accumulator: built up one binary bit per step, then read out from the
// top digit down, one digit per shift.
module sitda_bcd_reg #(
    parameter int NDIG = 10
) (
    input  wire logic               i_clk,
    input  wire sitda_pkg::t_bcd_cmd i_cmd,
    input  wire logic               i_bit,
    output logic      [3:0]         o_top_digit
);

    logic [NDIG*4-1:0] r_bcd;
    logic [NDIG*4-1:0] n_bcd;
    logic [NDIG*4-1:0] step_bcd;

    sitda_dabble #(
        .NDIG (NDIG)
    ) u_dabble (
        .i_bcd (r_bcd),
        .i_bit (i_bit),
        .o_bcd (step_bcd)
    );

    always_comb begin
        n_bcd = r_bcd;
        if (i_cmd.clear) begin
            n_bcd = '0;
        end else if (i_cmd.step) begin
            n_bcd = step_bcd;
        end else if (i_cmd.shift) begin
            n_bcd = {r_bcd[NDIG*4-5:0], 4'b0000};
        end
    end

    always_ff @(posedge i_clk) begin
        r_bcd <= n_bcd;
    end

    assign o_top_digit = r_bcd[NDIG*4-1 -: 4];

endmodule

`default_nettype wire

FILE: design/signed_int_to_decimal_ascii.sv
// Signed integer to decimal ASCII. One DATA_WIDTH-bit two's complement value
// per input beat; out come its characters, most significant first: '-' for a
// negative value, then the digits with no leading zeros ('0' alone for zero),
// the final character flagged with o_last. The most negative value converts
// exactly. One value at a time: o_ready is high only while idle. A value is
// accepted, converted by one double-dabble step per magnitude bit through a
// shared shift-add-3 unit, stripped of leading zeros, then sent out at one
// character per cycle while the sink is ready; the output stalls while the
// sink holds i_ready low. The BCD register holds NDIG digits, where NDIG =
// floor(DATA_WIDTH*log10(2)) + 1 (10 at 32 bits).
`timescale 1ns / 1ps
`default_nettype none

`include "signed_int_to_decimal_ascii_macros.svh"

module signed_int_to_decimal_ascii #(
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire logic signed [DATA_WIDTH-1:0] i_value,
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output logic             [7:0]            o_ascii_char,
    output logic                              o_last
);

    localparam int NDIG   = ((DATA_WIDTH * 1233) >> 12) + 1;
    localparam int CNT_W  = $clog2(DATA_WIDTH + 1);
    localparam int LEFT_W = $clog2(NDIG + 1);

    sitda_pkg::t_state   r_state, n_state;
    logic                r_neg, n_neg;
    logic [DATA_WIDTH-1:0] r_mag, n_mag;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic [LEFT_W-1:0]   r_left, n_left;

    sitda_pkg::t_bcd_cmd bcd_cmd;
    logic [3:0]          top_digit;

    logic                in_conv;
    logic                in_skip;
    logic                in_emit;
    logic                digit_ok;

    sitda_bcd_reg #(
        .NDIG (NDIG)
    ) u_bcd (
        .i_clk       (i_clk),
        .i_cmd       (bcd_cmd),
        .i_bit       (r_mag[DATA_WIDTH-1]),
        .o_top_digit (top_digit)
    );

    always_comb begin
        n_state = r_state;
        n_neg   = r_neg;
        n_mag   = r_mag;
        n_cnt   = r_cnt;
        n_left  = r_left;
        bcd_cmd = '0;
        case (r_state)
            sitda_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_neg = i_value[DATA_WIDTH-1];
                    if (i_value[DATA_WIDTH-1]) begin
                        n_mag = ~$unsigned(i_value) + DATA_WIDTH'(1);
                    end else begin
                        n_mag = $unsigned(i_value);
                    end
                    n_cnt         = CNT_W'(DATA_WIDTH);
                    bcd_cmd.clear = 1'b1;
                    n_state       = sitda_pkg::S_CONV;
                end
            end
            sitda_pkg::S_CONV: begin
                bcd_cmd.step = 1'b1;
                n_mag        = {r_mag[DATA_WIDTH-2:0], 1'b0};
                n_cnt        = r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    n_left  = LEFT_W'(NDIG);
                    n_state = sitda_pkg::S_SKIP;
                end
            end
            sitda_pkg::S_SKIP: begin
                // strip leading zeros, always keeping the last digit
                if (top_digit == 4'd0 && r_left != LEFT_W'(1)) begin
                    bcd_cmd.shift = 1'b1;
                    n_left        = r_left - LEFT_W'(1);
                end else if (r_neg) begin
                    n_state = sitda_pkg::S_SIGN;
                end else begin
                    n_state = sitda_pkg::S_EMIT;
                end
            end
            sitda_pkg::S_SIGN: begin
                if (i_ready) begin
                    n_state = sitda_pkg::S_EMIT;
                end
            end
            sitda_pkg::S_EMIT: begin
                if (i_ready) begin
                    if (r_left == LEFT_W'(1)) begin
                        n_state = sitda_pkg::S_IDLE;
                    end else begin
                        bcd_cmd.shift = 1'b1;
                        n_left        = r_left - LEFT_W'(1);
                    end
                end
            end
            default: begin
                n_state = sitda_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sitda_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_neg  <= n_neg;
        r_mag  <= n_mag;
        r_cnt  <= n_cnt;
        r_left <= n_left;
    end

    assign in_conv  = (r_state == sitda_pkg::S_CONV);
    assign in_skip  = (r_state == sitda_pkg::S_SKIP);
    assign in_emit  = (r_state == sitda_pkg::S_EMIT);
    assign digit_ok = (o_ascii_char >= sitda_pkg::ASCII_ZERO)
                   && (o_ascii_char <= sitda_pkg::ASCII_NINE);

    assign o_ready = (r_state == sitda_pkg::S_IDLE);
    assign o_valid = (r_state == sitda_pkg::S_SIGN) || in_emit;
    assign o_ascii_char = (r_state == sitda_pkg::S_SIGN) ? sitda_pkg::ASCII_MINUS
                        : sitda_pkg::ASCII_ZERO + {4'b0000, top_digit};
    assign o_last = in_emit && (r_left == LEFT_W'(1));

    `SITDA_ASSERT_NOW(a_busy_not_ready, i_clk, i_rst_n, o_valid, !o_ready)
    `SITDA_ASSERT_NOW(a_digit_range, i_clk, i_rst_n, in_emit, digit_ok)
    `SITDA_ASSERT_NEXT(a_last_to_idle, i_clk, i_rst_n, o_valid && i_ready && o_last, o_ready)
    `SITDA_ASSERT_NOW(a_conv_count, i_clk, i_rst_n, in_conv, r_cnt != CNT_W'(0))
    `SITDA_ASSERT_NOW(a_left_nonzero, i_clk, i_rst_n, o_valid || in_skip, r_left != LEFT_W'(0))

endmodule

`default_nettype wire

FILE: tb/tb_signed_int_to_decimal_ascii.sv
`timescale 1ns / 1ps

module tb_signed_int_to_decimal_ascii;

    localparam int DW         = 32;
    localparam int CYCLE_LIMIT = 400000;
    localparam int TAIL_CYCLES = 80;
    localparam int RANDOM_VALUES = 104;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_text_char;

    // Expected decimal text, one entry per character beat
    class t_text_board;
        t_text_char pending_chars[$];
        int         errors;

        function new();
            errors = 0;
        endfunction

        // Work out the characters that one accepted value must produce
        function void add_value(logic [DW-1:0] value);
            logic          negative;
            logic [DW-1:0] mag;
            logic [7:0]    digit_chars[$];
            t_text_char    c;
            negative = value[DW-1];
            mag = negative ? (~value + 1'b1) : value;
            do begin
                digit_chars.push_front(sitda_pkg::ASCII_ZERO + 8'(mag % 10));
                mag = mag / 10;
            end while (mag != 0);
            if (negative) begin
                c.ch   = sitda_pkg::ASCII_MINUS;
                c.last = 1'b0;
                pending_chars.push_back(c);
            end
            foreach (digit_chars[i]) begin
                c.ch   = digit_chars[i];
                c.last = (i == digit_chars.size() - 1);
                pending_chars.push_back(c);
            end
        endfunction

        function void check_char(logic [7:0] ch, logic last);
            t_text_char want;
            if (pending_chars.size() == 0) begin
                $display("%0t: unexpected char beat: expected none, got char %h last %b",
                         $time, ch, last);
                errors++;
                return;
            end
            want = pending_chars.pop_front();
            if (ch !== want.ch) begin
                $display("%0t: char mismatch: expected %h, got %h", $time, want.ch, ch);
                errors++;
            end
            if (last !== want.last) begin
                $display("%0t: last mismatch: expected %b, got %b", $time, want.last, last);
                errors++;
            end
        endfunction

        function int chars_left();
            return pending_chars.size();
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_ready;
    logic signed [DW-1:0] i_value;
    logic                 o_valid;
    logic                 i_ready;
    logic [7:0]           o_ascii_char;
    logic                 o_last;

    t_text_board text_board;
    int  cycle_count;
    bit  tx_idles;
    bit  rx_idles;

    signed_int_to_decimal_ascii #(
        .DATA_WIDTH(DW)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_value     (i_value),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_ascii_char(o_ascii_char),
        .o_last      (o_last)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[signed_int_to_decimal_ascii] ERROR");
            $finish;
        end
    end

    function automatic int idle_gap(bit enabled);
        return enabled ? $urandom_range(0, 12) : 0;
    endfunction

    // Valid stays high after the beat; the next call either keeps it up or drops it
    task automatic send_value(logic signed [DW-1:0] value);
        int gap;
        gap = idle_gap(tx_idles);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_value <= value;
        do @(posedge i_clk); while (!o_ready);
        text_board.add_value(value);
    endtask

    task automatic drain_text();
        i_valid <= 1'b0;
        while (text_board.chars_left() != 0) @(posedge i_clk);
    endtask

    function automatic logic signed [DW-1:0] random_value();
        int unsigned pow10 [0:9] = '{1, 10, 100, 1000, 10000, 100000, 1000000,
                                     10000000, 100000000, 1000000000};
        logic signed [DW-1:0] v;
        int unsigned          n;
        n = $urandom_range(0, 9);
        case ($urandom_range(0, 5))
            0, 1: v = $urandom;
            2, 3: v = (n == 9) ? $urandom_range(0, 32'h7FFFFFFF)
                               : $urandom_range(0, pow10[n + 1] - 1);
            4:    v = pow10[n] + $urandom_range(0, 2) - 1;
            default: begin
                case ($urandom_range(0, 3))
                    0: v = 32'h7FFFFFFF;
                    1: v = 32'h80000000;
                    2: v = 32'h80000001;
                    default: v = 0;
                endcase
            end
        endcase
        if ($urandom_range(0, 1) && v != 32'h80000000)
            v = -v;
        return v;
    endfunction

    // Sink side
    initial begin
        int gap;
        i_ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            gap = idle_gap(rx_idles);
            if (gap > 0) begin
                i_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
            text_board.check_char(o_ascii_char, o_last);
        end
    end

    initial begin
        logic signed [DW-1:0] directed_values[$];
        text_board  = new();
        tx_idles    = 1'b1;
        rx_idles    = 1'b1;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_value <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        directed_values = '{0, 1, -1, 9, -9, 10, -10, 99, 100, -100,
                            32'sh7FFFFFFF, 32'sh80000000, 32'sh80000001,
                            1000000000, -1000000000, 999999999, -999999999,
                            123456789, -5, 32'sh55555555, 32'shAAAAAAAA,
                            2000000000, -2147483647, 7};
        foreach (directed_values[i])
            send_value(directed_values[i]);

        for (int i = 0; i < RANDOM_VALUES; i++) begin
            // idling pattern changes every 26 values; one stretch runs flat out
            if (i % 26 == 0) begin
                tx_idles = (i / 26) % 2 == 0;
                rx_idles = (i / 26) != 2 && (i / 26) != 3;
            end
            if (i == 65)
                drain_text();
            send_value(random_value());
        end
        drain_text();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (text_board.errors == 0 && text_board.chars_left() == 0) begin
            $display("[signed_int_to_decimal_ascii] OK");
        end else begin
            $display("[signed_int_to_decimal_ascii] ERROR");
        end
        $finish;
    end

endmodule
